[rtl/xsc_pkg.sv]
// Shared types and constants for the xor stream cipher with fold tag.
// Used by the key unit, the tag memory, the top level and the port checker.
// No dependencies.
`timescale 1ns / 1ps

package xsc_pkg;

  // fixed geometry
  localparam int unsigned KEY_BYTES = 32;
  localparam int unsigned TAG_BYTES = 16;
  localparam int unsigned POS_W     = $clog2(KEY_BYTES);
  localparam int unsigned TAG_AW    = $clog2(TAG_BYTES);
  localparam int unsigned TCNT_W    = TAG_AW + 1;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_DW    = 64;
  localparam int unsigned CFG_IW    = 3;
  localparam int unsigned ROT_W     = 16;

  localparam logic [ROT_W-1:0] ROTATE_RESET = 16'd1000;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_KEY0   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_KEY1   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_KEY2   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_KEY3   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ROTATE = 3'd4;

  // operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_TAG    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // verdict codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISMATCH  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXEC    = 5'b00010,
    S_TAG_RD  = 5'b00100,
    S_TAG_OUT = 5'b01000,
    S_VERDICT = 5'b10000
  } state_e;

  // configuration write transaction
  typedef struct packed {
    logic              we;
    logic [CFG_IW-1:0] idx;
    logic [CFG_DW-1:0] wdata;
  } cfg_wr_t;

  // tag memory write request
  typedef struct packed {
    logic              we;
    logic [TAG_AW-1:0] addr;
    logic [7:0]        data;
  } tag_wr_t;

endpackage

[rtl/xsc_key_unit.sv]
// Key registers, rotate threshold, key offset and rotation counter.
// Provides the offset key byte for a byte position. Depends on xsc_pkg.
`timescale 1ns / 1ps

module xsc_key_unit import xsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_wr_t          cfg_i,
  input  logic             rotate_i,
  input  logic [POS_W-1:0] pos_i,
  output logic [7:0]       key_byte_o
);

  logic [KEY_WORDS-1:0][CFG_DW-1:0] key_q;
  logic [ROT_W-1:0]                 rotate_after_q;
  logic [7:0]                       offset_q, offset_d;
  logic [ROT_W-1:0]                 rot_cnt_q, rot_cnt_d;
  logic [ROT_W-1:0]                 rot_next;
  logic [CFG_DW-1:0]                key_word;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q          <= '0;
      rotate_after_q <= ROTATE_RESET;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_KEY0:   key_q[0] <= cfg_i.wdata;
        CFG_KEY1:   key_q[1] <= cfg_i.wdata;
        CFG_KEY2:   key_q[2] <= cfg_i.wdata;
        CFG_KEY3:   key_q[3] <= cfg_i.wdata;
        CFG_ROTATE: rotate_after_q <= cfg_i.wdata[ROT_W-1:0];
        default:    ;
      endcase
    end
  end

  // message counter advances per encrypted message, offset at threshold
  always_comb begin
    rot_next  = rot_cnt_q + {{(ROT_W-1){1'b0}}, 1'b1};
    offset_d  = offset_q;
    rot_cnt_d = rot_cnt_q;
    if (rotate_i) begin
      if (rot_next >= rotate_after_q) begin
        offset_d  = offset_q + 8'd1;
        rot_cnt_d = '0;
      end else begin
        rot_cnt_d = rot_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      rot_cnt_q <= '0;
    end else begin
      offset_q  <= offset_d;
      rot_cnt_q <= rot_cnt_d;
    end
  end

  // key byte lookup plus offset
  assign key_word   = key_q[pos_i[POS_W-1:3]];
  assign key_byte_o = key_word[{pos_i[2:0], 3'b000} +: 8] + offset_q;

endmodule

[rtl/xsc_tag_mem.sv]
// Fold tag accumulator: 16 x 8 synchronous memory with a registered read, read data in
// the cycle after the request, and per-entry valid bits so a whole message clears at once. Depends on xsc_pkg.
`timescale 1ns / 1ps

module xsc_tag_mem import xsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              re_i,
  input  logic [TAG_AW-1:0] raddr_i,
  input  tag_wr_t           wr_i,
  input  logic              clr_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0]           mem_q [TAG_BYTES];
  logic [TAG_BYTES-1:0] valid_q;
  logic [7:0]           rd_q;
  logic                 rd_valid_q;

  // storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  // valid bits: an entry not written this message reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : 8'h00;

endmodule

[rtl/xor_stream_cipher_with_fold_tag.sv]
// Top level of the xor stream cipher with 16-byte fold tag.
// Depends on xsc_pkg, xsc_key_unit and xsc_tag_mem.
//
//   channel  | signals                                              | dir
//   ---------+------------------------------------------------------+-----
//   input    | in_valid_i/in_ready_o, operation, data_in, tag_flag, | in
//            | no_data, end_of_message                              |
//   output   | out_valid_o/out_ready_i, data_out, kind, status,     | out
//            | last_of_run                                          |
//   config   | cfg_we_i, cfg_idx_i, cfg_wdata_i                     | in
//
// An item with a byte is accepted with a tag memory read; in S_EXEC a payload byte
// is modified and written back, a tag byte compared. An item with neither byte nor
// end stays in S_IDLE. Encrypt end of message adds a read then an emit per tag byte
// (S_TAG_RD, then S_TAG_OUT); decrypt end adds S_VERDICT. The registered tag memory
// read sets these. Reset clears control state and tag valid bits at once; no
// clearing pass. A stalled output holds the sequencer in place with nothing lost.
`timescale 1ns / 1ps

module xor_stream_cipher_with_fold_tag import xsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [7:0]        data_in_i,
  input  logic              tag_flag_i,
  input  logic              no_data_i,
  input  logic              end_of_message_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        data_out_o,
  output logic [1:0]        kind_o,
  output logic [1:0]        status_o,
  output logic              last_of_run_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  state_e state_q, state_d;

  // captured transaction
  logic       op_q, tag_q, has_q, eom_q;
  logic [7:0] din_q;

  // message state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [TCNT_W-1:0] tbs_q, tbs_d;
  logic              mm_q, mm_d;
  logic              ord_q, ord_d;
  logic [TAG_AW-1:0] idx_q, idx_d;
  logic              clr_msg;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;
  logic [1:0] out_kind_q, out_kind_d;
  logic [1:0] out_st_q, out_st_d;
  logic       out_last_q, out_last_d;
  logic       out_load, out_free;

  // memory and key signals
  logic              mem_re;
  logic [TAG_AW-1:0] mem_raddr;
  tag_wr_t           mem_wr;
  logic [7:0]        acc;
  logic [7:0]        key_byte;
  logic [7:0]        xb;
  logic              rotate;
  cfg_wr_t           cfg;
  logic              accept;

  // item decode
  logic is_pay, is_tag, pay_ok;

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  xsc_key_unit u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .rotate_i   (rotate),
    .pos_i      (pos_q),
    .key_byte_o (key_byte)
  );

  xsc_tag_mem u_tag (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (mem_re),
    .raddr_i   (mem_raddr),
    .wr_i      (mem_wr),
    .clr_i     (clr_msg),
    .rd_data_o (acc)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign xb     = din_q ^ key_byte;
  assign is_pay = has_q && ((op_q == OP_ENCRYPT) || !tag_q);
  assign is_tag = has_q && (op_q == OP_DECRYPT) && tag_q;
  assign pay_ok = is_pay && ((op_q == OP_ENCRYPT) || (tbs_q == '0));

  // memory read address: tag slot for a received tag byte or the tag readout, else position
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = pos_q[TAG_AW-1:0];
    if (state_q == S_IDLE) begin
      mem_re = accept;
      if ((operation_i == OP_DECRYPT) && tag_flag_i) begin
        mem_raddr = tbs_q[TAG_AW-1:0];
      end
    end else if (state_q == S_TAG_RD) begin
      mem_re    = 1'b1;
      mem_raddr = idx_q;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    tbs_d       = tbs_q;
    mm_d        = mm_q;
    ord_d       = ord_q;
    idx_d       = idx_q;
    clr_msg     = 1'b0;
    rotate      = 1'b0;
    mem_wr.we   = 1'b0;
    mem_wr.addr = pos_q[TAG_AW-1:0];
    mem_wr.data = acc ^ ((op_q == OP_ENCRYPT) ? din_q : xb);
    out_load    = 1'b0;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_st_d    = out_st_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept && !(no_data_i && !end_of_message_i)) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (!pay_ok || out_free) begin
          if (pay_ok) begin
            mem_wr.we  = 1'b1;
            pos_d      = pos_q + {{(POS_W-1){1'b0}}, 1'b1};
            out_load   = 1'b1;
            out_data_d = xb;
            out_kind_d = KIND_BYTE;
            out_st_d   = ST_OK;
            out_last_d = !eom_q;
          end else if (is_pay) begin
            // payload after a tag byte
            ord_d = 1'b1;
          end
          if (is_tag) begin
            if (tbs_q[TCNT_W-1]) begin
              ord_d = 1'b1;
            end else begin
              if (acc != din_q) begin
                mm_d = 1'b1;
              end
              tbs_d = tbs_q + {{(TCNT_W-1){1'b0}}, 1'b1};
            end
          end
          idx_d = '0;
          if (!eom_q) begin
            state_d = S_IDLE;
          end else if (op_q == OP_ENCRYPT) begin
            state_d = S_TAG_RD;
          end else begin
            state_d = S_VERDICT;
          end
        end
      end

      S_TAG_RD: begin
        state_d = S_TAG_OUT;
      end

      S_TAG_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = acc;
          out_kind_d = KIND_TAG;
          out_st_d   = ST_OK;
          out_last_d = (idx_q == TAG_AW'(TAG_BYTES - 1));
          if (idx_q == TAG_AW'(TAG_BYTES - 1)) begin
            clr_msg = 1'b1;
            rotate  = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + {{(TAG_AW-1){1'b0}}, 1'b1};
            state_d = S_TAG_RD;
          end
        end
      end

      S_VERDICT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = 8'h00;
          out_kind_d = KIND_STATUS;
          out_last_d = 1'b1;
          if (ord_q || (tbs_q != TCNT_W'(TAG_BYTES))) begin
            out_st_d = ST_MALFORMED;
          end else if (mm_q) begin
            out_st_d = ST_MISMATCH;
          end else begin
            out_st_d = ST_OK;
          end
          clr_msg = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (clr_msg) begin
      pos_d = '0;
      tbs_d = '0;
      mm_d  = 1'b0;
      ord_d = 1'b0;
    end
  end

  // output valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      tbs_q       <= '0;
      mm_q        <= 1'b0;
      ord_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      tbs_q       <= tbs_d;
      mm_q        <= mm_d;
      ord_q       <= ord_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      din_q <= data_in_i;
      tag_q <= tag_flag_i;
      has_q <= !no_data_i;
      eom_q <= end_of_message_i;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_out_o    = out_data_q;
  assign kind_o        = out_kind_q;
  assign status_o      = out_st_q;
  assign last_of_run_o = out_last_q;

endmodule

[rtl/xsc_port_checker.sv]
// Port-level checks for the xor stream cipher with fold tag, plus the bind
// that attaches them to the top level. Depends on xsc_pkg.
`timescale 1ns / 1ps

module xsc_port_checker import xsc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       no_data_i,
  input logic       end_of_message_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] data_out_o,
  input logic [1:0] kind_o,
  input logic [1:0] status_o,
  input logic       last_of_run_o
);

  // stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_out_o)
      && $stable(kind_o) && $stable(status_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // status code only carried by a verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_STATUS) |-> status_o == ST_OK)
    else $error("status set on a byte result");

  // verdict closes its run and carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_STATUS) |-> last_of_run_o && (data_out_o == 8'h00))
    else $error("malformed verdict");

  // a transaction that produces work drops ready in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !(no_data_i && !end_of_message_i) |=> !in_ready_o)
    else $error("input taken while busy");

  // no undefined kind code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o != 2'd3)
    else $error("bad kind code");

endmodule

bind xor_stream_cipher_with_fold_tag xsc_port_checker u_port_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .no_data_i        (no_data_i),
  .end_of_message_i (end_of_message_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .data_out_o       (data_out_o),
  .kind_o           (kind_o),
  .status_o         (status_o),
  .last_of_run_o    (last_of_run_o)
);
